FILE: design/atl_pkg.sv
package atl_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int LEN_W             = 16;
  localparam int QUEUE_DEPTH       = 4;

  localparam logic [3:0] KIND_COMMENT  = 4'd0;
  localparam logic [3:0] KIND_NAME     = 4'd1;
  localparam logic [3:0] KIND_LABEL    = 4'd2;
  localparam logic [3:0] KIND_NUMBER   = 4'd3;
  localparam logic [3:0] KIND_LBRACKET = 4'd4;
  localparam logic [3:0] KIND_RBRACKET = 4'd5;
  localparam logic [3:0] KIND_COMMA    = 4'd6;
  localparam logic [3:0] KIND_PLUS     = 4'd7;
  localparam logic [3:0] KIND_ERROR    = 4'd8;
  localparam logic [3:0] KIND_END      = 4'd9;

  typedef struct packed {
    logic [3:0]       kind;
    logic [LEN_W-1:0] start;
    logic [LEN_W-1:0] length;
    logic             last;
  } token_t;

  // up to two result words per character, a first then b
  typedef struct packed {
    logic [1:0] cnt;
    token_t     a;
    token_t     b;
  } wr_t;

endpackage

FILE: design/atl_core.sv
module atl_core #(
  parameter int POSITION_BITS = atl_pkg::POSITION_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_ch,
  input  logic           space_ok,
  output atl_pkg::wr_t   wr
);

  localparam int LW = atl_pkg::LEN_W;

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_COMMENT = 3'd1;
  localparam logic [2:0] MODE_NAME    = 3'd2;
  localparam logic [2:0] MODE_LABEL   = 3'd3;
  localparam logic [2:0] MODE_NUMBER  = 3'd4;
  localparam logic [2:0] MODE_ERROR   = 3'd5;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_PLUS  = 8'h2B;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic in_number(input logic [7:0] c);
    return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || c == CH_X;
  endfunction

  logic                     stg_v_r;
  logic [7:0]               ch_r;
  logic [2:0]               mode_r, mode_nxt;
  logic [LW-1:0]            plen_r, plen_nxt;
  logic [LW-1:0]            pstart_r, pstart_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic                     adv;

  logic                     extend;
  logic                     pend_act;
  logic [3:0]               pend_kind;
  logic                     e0, e1;
  logic [3:0]               k1;
  logic [LW-1:0]            l1;
  logic [LW-1:0]            pos16;
  atl_pkg::token_t          t0, t1;

  assign adv      = stg_v_r && space_ok;
  assign in_ready = !stg_v_r || adv;
  assign pos16    = LW'(pos_r);

  always_comb begin
    mode_nxt   = mode_r;
    plen_nxt   = plen_r;
    pstart_nxt = pstart_r;
    pos_nxt    = pos_r + POSITION_BITS'(1);
    extend     = 1'b0;
    pend_act   = 1'b1;
    pend_kind  = atl_pkg::KIND_COMMENT;
    e0         = 1'b0;
    e1         = 1'b0;
    k1         = atl_pkg::KIND_END;
    l1         = '0;

    unique case (mode_r)
      MODE_COMMENT: begin
        extend    = ch_r != CH_NL && ch_r != CH_NUL;
        pend_kind = atl_pkg::KIND_COMMENT;
      end
      MODE_NAME: begin
        extend    = is_letter(ch_r);
        pend_kind = atl_pkg::KIND_NAME;
      end
      MODE_LABEL: begin
        extend    = is_letter(ch_r);
        pend_kind = atl_pkg::KIND_LABEL;
      end
      MODE_NUMBER: begin
        extend    = in_number(ch_r);
        pend_kind = atl_pkg::KIND_NUMBER;
      end
      default: pend_act = 1'b0;
    endcase

    if (mode_r == MODE_ERROR) begin
      if (ch_r == CH_NUL) begin
        e1         = 1'b1;
        mode_nxt   = MODE_IDLE;
        plen_nxt   = '0;
        pstart_nxt = '0;
        pos_nxt    = '0;
      end
    end else if (pend_act && extend) begin
      if (plen_r != {LW{1'b1}}) begin
        plen_nxt = plen_r + LW'(1);
      end
    end else begin
      e0         = pend_act;
      mode_nxt   = MODE_IDLE;
      plen_nxt   = '0;
      pstart_nxt = '0;
      priority if (ch_r == CH_SPACE || ch_r == CH_NL) begin
      end else if (ch_r == CH_SEMI) begin
        mode_nxt = MODE_COMMENT; pstart_nxt = pos16; plen_nxt = LW'(1);
      end else if (is_letter(ch_r)) begin
        mode_nxt = MODE_NAME; pstart_nxt = pos16; plen_nxt = LW'(1);
      end else if (ch_r == CH_COLON) begin
        mode_nxt = MODE_LABEL; pstart_nxt = pos16; plen_nxt = LW'(1);
      end else if (is_digit(ch_r)) begin
        mode_nxt = MODE_NUMBER; pstart_nxt = pos16; plen_nxt = LW'(1);
      end else if (ch_r == CH_LBRK) begin
        e1 = 1'b1; k1 = atl_pkg::KIND_LBRACKET; l1 = LW'(1);
      end else if (ch_r == CH_RBRK) begin
        e1 = 1'b1; k1 = atl_pkg::KIND_RBRACKET; l1 = LW'(1);
      end else if (ch_r == CH_COMMA) begin
        e1 = 1'b1; k1 = atl_pkg::KIND_COMMA; l1 = LW'(1);
      end else if (ch_r == CH_PLUS) begin
        e1 = 1'b1; k1 = atl_pkg::KIND_PLUS; l1 = LW'(1);
      end else if (ch_r == CH_NUL) begin
        e1 = 1'b1; pos_nxt = '0;
      end else begin
        e1 = 1'b1; k1 = atl_pkg::KIND_ERROR; l1 = LW'(1);
        mode_nxt = MODE_ERROR;
      end
    end

    t0.kind   = pend_kind;
    t0.start  = pstart_r;
    t0.length = plen_r;
    t0.last   = !e1;
    t1.kind   = k1;
    t1.start  = pos16;
    t1.length = l1;
    t1.last   = 1'b1;

    wr.a   = e0 ? t0 : t1;
    wr.b   = t1;
    wr.cnt = adv ? (2'(e0) + 2'(e1)) : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r  <= 1'b0;
      mode_r   <= MODE_IDLE;
      plen_r   <= '0;
      pstart_r <= '0;
      pos_r    <= '0;
    end else begin
      if (in_ready) begin
        stg_v_r <= in_valid;
      end
      if (adv) begin
        mode_r   <= mode_nxt;
        plen_r   <= plen_nxt;
        pstart_r <= pstart_nxt;
        pos_r    <= pos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      ch_r <= in_ch;
    end
  end

endmodule

FILE: design/atl_fifo.sv
module atl_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  atl_pkg::wr_t    wr,
  output logic            space_ok,
  output logic            out_valid,
  input  logic            out_ready,
  output atl_pkg::token_t out_tok
);

  localparam int DEPTH = atl_pkg::QUEUE_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  atl_pkg::token_t mem_r [DEPTH];
  logic [AW-1:0]   wp_r, rp_r;
  logic [CW-1:0]   cnt_r;
  logic            pop;

  assign out_valid = cnt_r != '0;
  assign out_tok   = mem_r[rp_r];
  assign pop       = out_valid && out_ready;
  assign space_ok  = cnt_r <= CW'(DEPTH - 2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_r + AW'(wr.cnt);
      rp_r  <= rp_r + AW'(pop);
      cnt_r <= cnt_r + CW'(wr.cnt) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (wr.cnt != 2'd0) begin
      mem_r[wp_r] <= wr.a;
    end
    if (wr.cnt == 2'd2) begin
      mem_r[wp_r + AW'(1)] <= wr.b;
    end
  end

endmodule

FILE: design/assembly_token_lexer_unit.sv
// A character accepted on in_valid && in_ready is registered in the core stage, which
// decodes it once the queue has room for two words and writes its words into the queue.
// Throughput: one character per cycle while the queue has that room; the queue's
// single output port gives the words out one at a time, a first then b.
// Reset: synchronous active-low rst_n clears mode, pending token, position and queue.
module assembly_token_lexer_unit #(
  parameter int POSITION_BITS = atl_pkg::POSITION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_ch,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_token_kind,
  output logic [15:0] out_token_start,
  output logic [15:0] out_token_length,
  output logic        out_last_of_run
);

  atl_pkg::wr_t    wr;
  atl_pkg::token_t tok;
  logic            space_ok;

  atl_core #(.POSITION_BITS(POSITION_BITS)) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_ch    (in_ch),
    .space_ok (space_ok),
    .wr       (wr)
  );

  atl_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (wr),
    .space_ok  (space_ok),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_tok   (tok)
  );

  assign out_token_kind   = tok.kind;
  assign out_token_start  = tok.start;
  assign out_token_length = tok.length;
  assign out_last_of_run  = tok.last;

endmodule

FILE: design/atl_checker.sv
module atl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [3:0]  out_token_kind,
  input logic [15:0] out_token_start,
  input logic [15:0] out_token_length,
  input logic        out_last_of_run
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out word dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_token_kind) && $stable(out_token_start)
      && $stable(out_token_length) && $stable(out_last_of_run))
    else $error("out word changed while stalled");

  a_end_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_token_kind == atl_pkg::KIND_END |->
      out_token_length == 16'd0 && out_last_of_run)
    else $error("end word malformed");

  a_single_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_token_kind == atl_pkg::KIND_LBRACKET
      || out_token_kind == atl_pkg::KIND_RBRACKET
      || out_token_kind == atl_pkg::KIND_COMMA
      || out_token_kind == atl_pkg::KIND_PLUS
      || out_token_kind == atl_pkg::KIND_ERROR) |->
      out_token_length == 16'd1 && out_last_of_run)
    else $error("single-character word malformed");

endmodule

bind assembly_token_lexer_unit atl_checker u_atl_checker (.*);
